FILE: rtl/slr_eval_pkg.sv
// slr_eval_pkg: shared types, constants and parse tables of the expression evaluator
// no dependencies
`timescale 1ns / 1ps
package slr_eval_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int VALUE_BITS  = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int STATE_W     = 4;

	typedef enum logic [2:0] {
		TOK_NUM  = 3'd0,
		TOK_PLUS = 3'd1,
		TOK_STAR = 3'd2,
		TOK_LPAR = 3'd3,
		TOK_RPAR = 3'd4,
		TOK_END  = 3'd5,
		TOK_ILL  = 3'd6
	} tok_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SYNTAX   = 2'd1,
		ST_ILLEGAL  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ACT_ERR    = 2'd0,
		ACT_SHIFT  = 2'd1,
		ACT_REDUCE = 2'd2,
		ACT_ACCEPT = 2'd3
	} act_kind_t;

	typedef enum logic [1:0] {
		NT_EXPR   = 2'd0,
		NT_TERM   = 2'd1,
		NT_FACTOR = 2'd2
	} nterm_t;

	localparam logic [2:0] RULE_ADD    = 3'd1;
	localparam logic [2:0] RULE_MUL    = 3'd3;
	localparam logic [2:0] RULE_PAREN  = 3'd5;

	typedef struct packed {
		act_kind_t            kind;
		logic [STATE_W-1:0]   arg;
	} act_t;

	typedef struct packed {
		tok_t                  tok;
		logic                  paired;
		logic [VALUE_BITS-1:0] value;
	} tok_entry_t;

	function automatic logic is_follow(input tok_t tok);
		return (tok == TOK_PLUS) || (tok == TOK_STAR) || (tok == TOK_RPAR) || (tok == TOK_END);
	endfunction

	function automatic act_t act_lookup(input logic [STATE_W-1:0] st, input tok_t tok);
		act_t a;
		a.kind = ACT_ERR;
		a.arg  = '0;
		unique case (st)
			4'd0, 4'd4, 4'd6, 4'd7: begin
				if (tok == TOK_NUM) begin
					a = '{ACT_SHIFT, 4'd5};
				end else if (tok == TOK_LPAR) begin
					a = '{ACT_SHIFT, 4'd4};
				end
			end
			4'd1: begin
				if (tok == TOK_PLUS) begin
					a = '{ACT_SHIFT, 4'd6};
				end else if (tok == TOK_END) begin
					a = '{ACT_ACCEPT, 4'd0};
				end
			end
			4'd2, 4'd9: begin
				if (tok == TOK_STAR) begin
					a = '{ACT_SHIFT, 4'd7};
				end else if (is_follow(tok)) begin
					a = '{ACT_REDUCE, (st == 4'd2) ? 4'd2 : 4'd1};
				end
			end
			4'd3: if (is_follow(tok)) a = '{ACT_REDUCE, 4'd4};
			4'd5: if (is_follow(tok)) a = '{ACT_REDUCE, 4'd6};
			4'd10: if (is_follow(tok)) a = '{ACT_REDUCE, 4'd3};
			4'd11: if (is_follow(tok)) a = '{ACT_REDUCE, 4'd5};
			4'd8: begin
				if (tok == TOK_PLUS) begin
					a = '{ACT_SHIFT, 4'd6};
				end else if (tok == TOK_RPAR) begin
					a = '{ACT_SHIFT, 4'd11};
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic logic [STATE_W-1:0] goto_lookup(input logic [STATE_W-1:0] st,
		input nterm_t lhs);
		logic [STATE_W-1:0] g;
		g = '0;
		unique case (st)
			4'd0: begin
				unique case (lhs)
					NT_EXPR: g = 4'd1;
					NT_TERM: g = 4'd2;
					default: g = 4'd3;
				endcase
			end
			4'd4: begin
				unique case (lhs)
					NT_EXPR: g = 4'd8;
					NT_TERM: g = 4'd2;
					default: g = 4'd3;
				endcase
			end
			4'd6: begin
				unique case (lhs)
					NT_EXPR: g = 4'd0;
					NT_TERM: g = 4'd9;
					default: g = 4'd3;
				endcase
			end
			4'd7: g = (lhs == NT_FACTOR) ? 4'd10 : 4'd0;
			default: g = '0;
		endcase
		return g;
	endfunction

	function automatic logic [1:0] rule_len(input logic [2:0] rule);
		return (rule == RULE_ADD || rule == RULE_MUL || rule == RULE_PAREN) ? 2'd3 : 2'd1;
	endfunction

	function automatic nterm_t rule_lhs(input logic [2:0] rule);
		nterm_t n;
		unique case (rule)
			3'd1, 3'd2: n = NT_EXPR;
			3'd3, 3'd4: n = NT_TERM;
			default:    n = NT_FACTOR;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/slr_eval_in_if.sv
// slr_eval_in_if: character channel of the expression evaluator
// depends on nothing
`timescale 1ns / 1ps
interface slr_eval_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;

	modport source(output valid, kind, char_code, input ready);
	modport sink(input valid, kind, char_code, output ready);
endinterface

FILE: rtl/slr_eval_out_if.sv
// slr_eval_out_if: result channel of the expression evaluator
// depends on nothing
`timescale 1ns / 1ps
interface slr_eval_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] result_value;

	modport source(output valid, status, result_value, input ready);
	modport sink(input valid, status, result_value, output ready);
endinterface

FILE: rtl/slr_expression_evaluator_top.sv
// slr_expression_evaluator_top: streaming arithmetic expression evaluator
// depends on slr_eval_pkg, the channel interfaces, front, fifo and back
//
// usage:
//   text carries one character (kind 0, char_code) or end of input (kind 1)
//   per transaction; result carries status and result_value per finished parse
//   blanks, tabs and newlines are skipped; digit runs form numbers mod 2^32
//   + * ( ) and end of input drive the slr parse; errors give a nonzero status
//   and a zero value, then the parse restarts from an empty stack
// throughput:
//   the front takes one character per cycle unless the token queue is full or a token
//   is pending: a token character that closes a number is pushed after the number
//   the back handles a shift or result in its decode state; a reduction starts the
//   stack ram read there, then does goto lookup, add or multiply and write back
// reset:
//   clears the stack pointer, number gatherer, token queue and result valid flag;
//   stack rams are not cleared and need no sweep
// stall:
//   a held result blocks the back; the 4-entry token queue then fills and
//   text.ready drops until the result is taken
`timescale 1ns / 1ps
module slr_expression_evaluator_top (
	input  logic             clk,
	input  logic             arst_n,
	slr_eval_in_if.sink      text,
	slr_eval_out_if.source   result
);
	logic                     push;
	slr_eval_pkg::tok_entry_t push_entry;
	logic                     full;
	logic                     pop;
	logic                     head_valid;
	slr_eval_pkg::tok_entry_t head_entry;

	slr_eval_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	slr_eval_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	slr_eval_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.result     (result)
	);
endmodule

FILE: rtl/slr_eval_ram.sv
// slr_eval_ram: generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps
module slr_eval_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/slr_eval_fifo.sv
// slr_eval_fifo: short token queue between the lexer front and the parser back
// depends on slr_eval_pkg
`timescale 1ns / 1ps
module slr_eval_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  slr_eval_pkg::tok_entry_t push_entry,
	output logic                     full,
	input  logic                     pop,
	output logic                     head_valid,
	output slr_eval_pkg::tok_entry_t head_entry
);
	localparam int QP_W = $clog2(slr_eval_pkg::QUEUE_DEPTH);
	localparam int QC_W = $clog2(slr_eval_pkg::QUEUE_DEPTH + 1);

	slr_eval_pkg::tok_entry_t entries_q [slr_eval_pkg::QUEUE_DEPTH];
	logic [QP_W-1:0] wr_ptr_q;
	logic [QP_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == QC_W'(slr_eval_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [QP_W-1:0] next_ptr(input logic [QP_W-1:0] p);
		return (p == QP_W'(slr_eval_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end
endmodule

FILE: rtl/slr_eval_front.sv
// slr_eval_front: accepts character transactions, gathers numbers, classifies tokens
// depends on slr_eval_pkg and slr_eval_in_if
`timescale 1ns / 1ps
module slr_eval_front (
	input  logic                     clk,
	input  logic                     arst_n,
	slr_eval_in_if.sink              text,
	output logic                     push,
	output slr_eval_pkg::tok_entry_t push_entry,
	input  logic                     full
);
	localparam int VB = slr_eval_pkg::VALUE_BITS;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;

	logic [VB-1:0]      acc_q;
	logic               in_num_q;
	logic               pend_q;
	slr_eval_pkg::tok_t pend_tok_q;

	logic               take;
	logic               is_digit;
	logic               has_sec;
	slr_eval_pkg::tok_t sec_tok;
	logic [VB-1:0]      acc_next;

	assign text.ready = !pend_q && !full;
	assign take       = text.valid && text.ready;
	assign is_digit   = !text.kind && (text.char_code >= CH_ZERO) && (text.char_code <= CH_NINE);
	assign acc_next   = (acc_q << 3) + (acc_q << 1) + VB'(text.char_code - CH_ZERO);

	always_comb begin
		has_sec = 1'b1;
		sec_tok = slr_eval_pkg::TOK_ILL;
		if (text.kind) begin
			sec_tok = slr_eval_pkg::TOK_END;
		end else begin
			unique case (text.char_code)
				CH_SPACE, CH_TAB, CH_LF: has_sec = 1'b0;
				CH_PLUS: sec_tok = slr_eval_pkg::TOK_PLUS;
				CH_STAR: sec_tok = slr_eval_pkg::TOK_STAR;
				CH_LPAR: sec_tok = slr_eval_pkg::TOK_LPAR;
				CH_RPAR: sec_tok = slr_eval_pkg::TOK_RPAR;
				default: sec_tok = slr_eval_pkg::TOK_ILL;
			endcase
		end
	end

	always_comb begin
		push              = 1'b0;
		push_entry.tok    = sec_tok;
		push_entry.paired = 1'b0;
		push_entry.value  = '0;
		priority if (pend_q) begin
			push           = !full;
			push_entry.tok = pend_tok_q;
		end else if (take && !is_digit) begin
			if (in_num_q) begin
				push              = 1'b1;
				push_entry.tok    = slr_eval_pkg::TOK_NUM;
				push_entry.paired = has_sec;
				push_entry.value  = acc_q;
			end else begin
				push = has_sec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			in_num_q   <= 1'b0;
			pend_q     <= 1'b0;
			pend_tok_q <= slr_eval_pkg::TOK_END;
		end else begin
			if (pend_q && !full) begin
				pend_q <= 1'b0;
			end
			if (take) begin
				if (is_digit) begin
					acc_q    <= acc_next;
					in_num_q <= 1'b1;
				end else if (in_num_q) begin
					acc_q      <= '0;
					in_num_q   <= 1'b0;
					pend_q     <= has_sec;
					pend_tok_q <= sec_tok;
				end
			end
		end
	end
endmodule

FILE: rtl/slr_eval_back.sv
// slr_eval_back: table-driven shift/reduce sequencer with ram stacks and result register
// depends on slr_eval_pkg, slr_eval_out_if and slr_eval_ram
`timescale 1ns / 1ps
module slr_eval_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  slr_eval_pkg::tok_entry_t head_entry,
	output logic                     pop,
	slr_eval_out_if.source           result
);
	localparam int VB   = slr_eval_pkg::VALUE_BITS;
	localparam int SP_W = slr_eval_pkg::SP_W;
	localparam int SW   = slr_eval_pkg::STATE_W;
	localparam logic [SP_W-1:0] SP_MAX = SP_W'(slr_eval_pkg::STACK_DEPTH - 1);

	typedef enum logic [1:0] {
		B_DEC = 2'b01,
		B_RED = 2'b10
	} bstate_t;

	bstate_t          st_q;
	logic [SP_W-1:0]  sp_q;
	logic [SW-1:0]    top_state_q;
	logic [VB-1:0]    top_val_q;
	logic             drop_q;
	logic [2:0]       rule_q;
	logic [SP_W-1:0]  base_q;
	logic             base_zero_q;
	logic             out_valid_q;
	slr_eval_pkg::status_t status_q;
	logic [VB-1:0]    value_q;

	slr_eval_pkg::act_t    act;
	logic [1:0]            len;
	logic                  out_free;
	logic                  go;
	logic                  emit;
	slr_eval_pkg::status_t emit_status;
	logic [VB-1:0]         emit_val;
	logic                  do_shift;
	logic                  red_start;
	logic                  red_wr;
	logic                  drop_clr;

	logic [SW-1:0]   st_rd;
	logic [VB-1:0]   val_rd;
	logic [SW-1:0]   new_state;
	logic [VB-1:0]   new_val;
	logic [2*VB-1:0] prod;
	logic            we;
	logic [SP_W-1:0] waddr;
	logic [SP_W-1:0] st_raddr;
	logic [SP_W-1:0] val_raddr;
	logic [SW-1:0]   st_wdata;
	logic [VB-1:0]   val_wdata;

	assign act      = slr_eval_pkg::act_lookup(top_state_q, head_entry.tok);
	assign len      = slr_eval_pkg::rule_len(act.arg[2:0]);
	assign out_free = !out_valid_q || result.ready;
	assign go       = (st_q == B_DEC) && head_valid && out_free;
	assign red_wr   = (st_q == B_RED);

	always_comb begin
		pop         = 1'b0;
		emit        = 1'b0;
		emit_status = slr_eval_pkg::ST_SYNTAX;
		emit_val    = '0;
		do_shift    = 1'b0;
		red_start   = 1'b0;
		drop_clr    = 1'b0;
		if (go) begin
			priority if (drop_q) begin
				pop      = 1'b1;
				drop_clr = 1'b1;
			end else if (head_entry.tok == slr_eval_pkg::TOK_ILL) begin
				pop         = 1'b1;
				emit        = 1'b1;
				emit_status = slr_eval_pkg::ST_ILLEGAL;
			end else begin
				unique case (act.kind)
					slr_eval_pkg::ACT_ACCEPT: begin
						pop         = 1'b1;
						emit        = 1'b1;
						emit_status = slr_eval_pkg::ST_OK;
						emit_val    = top_val_q;
					end
					slr_eval_pkg::ACT_SHIFT: begin
						pop = 1'b1;
						if (sp_q == SP_MAX) begin
							emit        = 1'b1;
							emit_status = slr_eval_pkg::ST_OVERFLOW;
						end else begin
							do_shift = 1'b1;
						end
					end
					slr_eval_pkg::ACT_REDUCE: begin
						if (sp_q < SP_W'(len)) begin
							pop  = 1'b1;
							emit = 1'b1;
						end else begin
							red_start = 1'b1;
						end
					end
					default: begin
						pop  = 1'b1;
						emit = 1'b1;
					end
				endcase
			end
		end
	end

	assign st_raddr  = sp_q - SP_W'(len);
	assign val_raddr = (act.arg[2:0] == slr_eval_pkg::RULE_PAREN) ? sp_q - 1'b1 : sp_q - 2'd2;

	assign prod = val_rd * top_val_q;
	always_comb begin
		unique case (rule_q)
			slr_eval_pkg::RULE_ADD:   new_val = val_rd + top_val_q;
			slr_eval_pkg::RULE_MUL:   new_val = prod[VB-1:0];
			slr_eval_pkg::RULE_PAREN: new_val = val_rd;
			default:                  new_val = top_val_q;
		endcase
	end
	assign new_state = slr_eval_pkg::goto_lookup(base_zero_q ? SW'(0) : st_rd,
		slr_eval_pkg::rule_lhs(rule_q));

	assign we        = do_shift || red_wr;
	assign waddr     = do_shift ? sp_q + 1'b1 : base_q + 1'b1;
	assign st_wdata  = do_shift ? act.arg : new_state;
	assign val_wdata = do_shift ? head_entry.value : new_val;

	slr_eval_ram #(.WIDTH(SW), .DEPTH(slr_eval_pkg::STACK_DEPTH)) u_state_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (st_wdata),
		.re    (red_start),
		.raddr (st_raddr),
		.rdata (st_rd)
	);

	slr_eval_ram #(.WIDTH(VB), .DEPTH(slr_eval_pkg::STACK_DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (val_wdata),
		.re    (red_start),
		.raddr (val_raddr),
		.rdata (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_DEC;
			sp_q        <= '0;
			top_state_q <= '0;
			top_val_q   <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (drop_clr) begin
				drop_q <= 1'b0;
			end
			if (emit) begin
				sp_q        <= '0;
				top_state_q <= '0;
				top_val_q   <= '0;
				drop_q      <= head_entry.paired;
			end else if (do_shift) begin
				sp_q        <= sp_q + 1'b1;
				top_state_q <= act.arg;
				top_val_q   <= head_entry.value;
			end
			unique case (st_q)
				B_DEC: if (red_start) st_q <= B_RED;
				B_RED: begin
					st_q        <= B_DEC;
					sp_q        <= base_q + 1'b1;
					top_state_q <= new_state;
					top_val_q   <= new_val;
				end
				default: st_q <= B_DEC;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (red_start) begin
			rule_q      <= act.arg[2:0];
			base_q      <= st_raddr;
			base_zero_q <= (sp_q == SP_W'(len));
		end
		if (emit) begin
			status_q <= emit_status;
			value_q  <= emit_val;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = status_q;
	assign result.result_value = 32'(value_q);
endmodule
